/* rtl/pis_pkg.sv */
// Shared types and constants for the point-in-shape hit test.
package pis_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_MUL        = 6;

    typedef enum logic [1:0] {
        FUNC_RECT   = 2'd0,
        FUNC_CIRCLE = 2'd1,
        FUNC_TRI    = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef struct packed {
        logic  valid;
        t_func func;
        logic  rect_hit;
        logic  rad_pos;
    } t_ctl;

endpackage

/* rtl/pis_front.sv */
// Input register, coordinate differences, rectangle test and multiplier operand select.
module pis_front import pis_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int D = COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [1:0]                   i_func,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    output t_ctl                         o_ctl,
    output logic signed [D-1:0]          o_op_a [NUM_MUL],
    output logic signed [D-1:0]          o_op_b [NUM_MUL]
);

    // request register
    logic                         r_a_vld;
    t_func                        r_a_func;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a_func <= t_func'(i_func);
            r_px     <= i_point_x;
            r_py     <= i_point_y;
            r_ax     <= i_a_x;
            r_ay     <= i_a_y;
            r_bx     <= i_b_x;
            r_by     <= i_b_y;
            r_cx     <= i_c_x;
            r_cy     <= i_c_y;
        end
    end

    // widened coordinates
    logic signed [D-1:0] px, py, ax, ay, bx, by, cx, cy;
    assign px = D'(r_px);
    assign py = D'(r_py);
    assign ax = D'(r_ax);
    assign ay = D'(r_ay);
    assign bx = D'(r_bx);
    assign by = D'(r_by);
    assign cx = D'(r_cx);
    assign cy = D'(r_cy);

    logic signed [D-1:0] dx, dy;
    logic signed [D-1:0] ux0, uy0, ux1, uy1, ux2, uy2;
    logic                rect_hit;
    logic signed [D-1:0] n_op_a [NUM_MUL];
    logic signed [D-1:0] n_op_b [NUM_MUL];
    t_ctl                n_ctl;

    // circle center offset and vertex offsets from the point
    assign dx  = px - ax - bx;
    assign dy  = py - ay - bx;
    assign ux0 = ax - px;
    assign uy0 = ay - py;
    assign ux1 = bx - px;
    assign uy1 = by - py;
    assign ux2 = cx - px;
    assign uy2 = cy - py;

    // half-open box; empty when width or height is not positive
    assign rect_hit = (px >= ax) && (px < ax + bx) && (py >= ay) && (py < ay + by);

    always_comb begin
        // triangle: three cross products, two products each
        n_op_a[0] = ux0;  n_op_b[0] = uy1;
        n_op_a[1] = ux1;  n_op_b[1] = uy0;
        n_op_a[2] = ux1;  n_op_b[2] = uy2;
        n_op_a[3] = ux2;  n_op_b[3] = uy1;
        n_op_a[4] = ux2;  n_op_b[4] = uy0;
        n_op_a[5] = ux0;  n_op_b[5] = uy2;
        case (r_a_func)
            FUNC_CIRCLE: begin
                n_op_a[0] = dx;  n_op_b[0] = dx;
                n_op_a[1] = bx;  n_op_b[1] = bx;
                n_op_a[2] = dy;  n_op_b[2] = dy;
            end
            default: begin
            end
        endcase
        n_ctl.valid    = r_a_vld;
        n_ctl.func     = r_a_func;
        n_ctl.rect_hit = rect_hit;
        n_ctl.rad_pos  = (bx > D'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_MUL; k++) begin
            o_op_a[k] <= n_op_a[k];
            o_op_b[k] <= n_op_b[k];
        end
    end

endmodule

/* rtl/pis_mul.sv */
// Bank of signed multipliers with registered products.
module pis_mul import pis_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int D = COORD_BITS + 2,
    localparam int P = 2 * D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic signed [D-1:0] i_op_a [NUM_MUL],
    input  logic signed [D-1:0] i_op_b [NUM_MUL],
    output t_ctl                o_ctl,
    output logic signed [P-1:0] o_prod [NUM_MUL]
);

    logic signed [P-1:0] n_prod [NUM_MUL];

    always_comb begin
        for (int k = 0; k < NUM_MUL; k++) begin
            n_prod[k] = P'(i_op_a[k]) * P'(i_op_b[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_MUL; k++) begin
            o_prod[k] <= n_prod[k];
        end
    end

endmodule

/* rtl/pis_decide.sv */
// Product combine, sign and range checks, and the result register.
module pis_decide import pis_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int D = COORD_BITS + 2,
    localparam int P = 2 * D,
    localparam int V = P + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic signed [P-1:0] i_prod [NUM_MUL],
    output logic                o_valid,
    output logic                o_hit
);

    t_ctl                r_d_ctl;
    logic signed [V-1:0] r_v0, r_v1, r_v2;
    logic signed [P-1:0] r_rsq;
    logic signed [V-1:0] n_v0;

    // circle: squared distance; triangle: first cross product
    assign n_v0 = (i_ctl.func == FUNC_CIRCLE) ? V'(i_prod[0]) + V'(i_prod[2])
                                              : V'(i_prod[0]) - V'(i_prod[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0  <= n_v0;
        r_v1  <= V'(i_prod[2]) - V'(i_prod[3]);
        r_v2  <= V'(i_prod[4]) - V'(i_prod[5]);
        r_rsq <= i_prod[1];
    end

    logic pos, neg, n_hit;

    assign pos = (r_v0 > V'(0)) || (r_v1 > V'(0)) || (r_v2 > V'(0));
    assign neg = r_v0[V-1] || r_v1[V-1] || r_v2[V-1];

    always_comb begin
        case (r_d_ctl.func)
            FUNC_RECT:   n_hit = r_d_ctl.rect_hit;
            FUNC_CIRCLE: n_hit = r_d_ctl.rad_pos && (r_v0 < V'(r_rsq));
            FUNC_TRI:    n_hit = !(pos && neg);
            default:     n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= n_hit;
    end

`ifndef NO_ASSERTIONS
    a_none_never_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_ctl.valid && r_d_ctl.func == FUNC_NONE) |=> !o_hit)
        else $error("unknown shape kind reported a hit");

    a_circle_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_ctl.valid && r_d_ctl.func == FUNC_CIRCLE && !r_d_ctl.rad_pos) |=> !o_hit)
        else $error("circle with non-positive radius reported a hit");
`endif

endmodule

/* rtl/point_in_shape_test.sv */
// Top level of the point-in-shape hit test.
//
// Answers one hit query per request: a point and a shape (rectangle, circle
// or triangle; kind 3 never hits). A request is taken at any rising edge with
// start high; busy stays low, so a new request may be issued every cycle and
// the block sustains one result per clock. Each request yields exactly one
// result, o_valid pulsing for one cycle with o_hit, in request order. The
// pipeline stages are the request register, difference and operand-select
// stage, multiplier bank, product combine stage and result register. Results
// cannot be held off: whoever issues requests must take o_valid/o_hit in the
// cycle they appear. Rectangles use half-open bounds, circles test squared
// distance strictly below radius squared (center = box corner + radius),
// triangles use exact cross-product signs so edge points and degenerate
// on-line points hit.
module point_in_shape_test import pis_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    output logic                         o_valid,
    output logic                         o_hit
);

    localparam int D = COORD_BITS + 2;
    localparam int P = 2 * D;

    // fully pipelined, never stalls
    assign busy = 1'b0;

    t_ctl                front_ctl, mul_ctl;
    logic signed [D-1:0] op_a [NUM_MUL];
    logic signed [D-1:0] op_b [NUM_MUL];
    logic signed [P-1:0] prod [NUM_MUL];

    // stage 1-2: request capture, offsets, rectangle test, operand select
    pis_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_func    (i_func),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_a_x     (i_a_x),
        .i_a_y     (i_a_y),
        .i_b_x     (i_b_x),
        .i_b_y     (i_b_y),
        .i_c_x     (i_c_x),
        .i_c_y     (i_c_y),
        .o_ctl     (front_ctl),
        .o_op_a    (op_a),
        .o_op_b    (op_b)
    );

    // stage 3: six multipliers, shared between circle and triangle
    pis_mul #(.COORD_BITS(COORD_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (front_ctl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_ctl   (mul_ctl),
        .o_prod  (prod)
    );

    // stages 4-5: combine products, decide, result register
    pis_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_prod  (prod),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

`ifndef NO_ASSERTIONS
    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("request produced no result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 5))
        else $error("result without a matching request");
`endif

endmodule
